FILE: rtl/acit_pkg.sv
// Shared types, register addresses and boot ROM contents for the audio CPU I/O and timer block.
package acit_pkg;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_CPU_RD  = 3'd1,
    KIND_CPU_WR  = 3'd2,
    KIND_HOST_WR = 3'd3,
    KIND_HOST_RD = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [1:0]  port;
    logic [7:0]  dsp_read_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       dsp_read_strobe;
    logic       dsp_write_strobe;
    logic [6:0] dsp_register;
    logic [7:0] dsp_write_data;
  } out_item_t;

  // Per-timer control for one beat.
  typedef struct packed {
    logic       tick;
    logic       ctl_wr;
    logic       en;
    logic       tgt_wr;
    logic [7:0] tgt;
    logic       cnt_clr;
  } tmr_ctl_t;

  localparam int RAM_DEPTH      = 65536;
  localparam int RAM_AW         = 16;
  localparam int BOOT_ROM_BYTES = 64;
  localparam int ROM_AW         = 6;
  localparam int IN_PORTS       = 6;
  localparam int OUT_PORTS      = 4;
  localparam int MAX_TIMERS     = 3;
  localparam int PRE_W          = 7;
  localparam int CNT_W          = 4;

  localparam logic [15:0] ADDR_TEST     = 16'h00f0;
  localparam logic [15:0] ADDR_CONTROL  = 16'h00f1;
  localparam logic [15:0] ADDR_DSP_ADDR = 16'h00f2;
  localparam logic [15:0] ADDR_DSP_DATA = 16'h00f3;
  localparam logic [15:0] ADDR_PORT0    = 16'h00f4;
  localparam logic [15:0] ADDR_PORT1    = 16'h00f5;
  localparam logic [15:0] ADDR_PORT2    = 16'h00f6;
  localparam logic [15:0] ADDR_PORT3    = 16'h00f7;
  localparam logic [15:0] ADDR_PORT4    = 16'h00f8;
  localparam logic [15:0] ADDR_PORT5    = 16'h00f9;
  localparam logic [15:0] ADDR_T0_TGT   = 16'h00fa;
  localparam logic [15:0] ADDR_T1_TGT   = 16'h00fb;
  localparam logic [15:0] ADDR_T2_TGT   = 16'h00fc;
  localparam logic [15:0] ADDR_T0_CNT   = 16'h00fd;
  localparam logic [15:0] ADDR_T1_CNT   = 16'h00fe;
  localparam logic [15:0] ADDR_T2_CNT   = 16'h00ff;
  localparam logic [15:0] ROM_BASE      = 16'hffc0;

  localparam int CTL_CLR_P01 = 4;
  localparam int CTL_CLR_P23 = 5;
  localparam int CTL_ROM_EN  = 7;

  localparam logic [7:0] BOOT_ROM [BOOT_ROM_BYTES] = '{
    8'hcd, 8'hef, 8'hbd, 8'he8, 8'h00, 8'hc6, 8'h1d, 8'hd0,
    8'hfc, 8'h8f, 8'haa, 8'hf4, 8'h8f, 8'hbb, 8'hf5, 8'h78,
    8'hcc, 8'hf4, 8'hd0, 8'hfb, 8'h2f, 8'h19, 8'heb, 8'hf4,
    8'hd0, 8'hfc, 8'h7e, 8'hf4, 8'hd0, 8'h0b, 8'he4, 8'hf5,
    8'hcb, 8'hf4, 8'hd7, 8'h00, 8'hfc, 8'hd0, 8'hf3, 8'hab,
    8'h01, 8'h10, 8'hef, 8'h7e, 8'hf4, 8'h10, 8'heb, 8'hba,
    8'hf6, 8'hda, 8'h00, 8'hba, 8'hf4, 8'hc4, 8'hf4, 8'hdd,
    8'h5d, 8'hd0, 8'hdb, 8'h1f, 8'h00, 8'h00, 8'hc0, 8'hff
  };

endpackage

FILE: rtl/audio_cpu_io_timers.sv
// Top level of the audio CPU memory, host port and interval timer block.
//
// Usage: drive item_i and raise start; a beat is taken at a rising edge where start
// is high and busy is low. Each beat is a timer tick, a CPU read or write, or a
// host port write or read. Every beat yields exactly one result beat on result_o,
// marked by done_o for one cycle: the beat is first held in valid_q and item_q
// for the decode, then its result is registered in result_q and done_q. The receiver
// has no backpressure and must take each result in the cycle it is shown.
// Throughput is one beat per cycle while busy is low: CPU writes go into RAM at the
// accept edge, the RAM read is launched at the same edge, and the decode of I/O
// registers, timers and ports runs in the following cycle before the result register.
// Reset clears the timers, ports, DSP address and sets the boot ROM overlay on,
// then zeroes the 64 KiB RAM one byte per cycle: busy stays high until the last
// byte is cleared, and no beat is taken during that pass.
// DSP accesses leave as strobes in the result beat: dsp_read_strobe with the
// register index on a read of the DSP data register, dsp_write_strobe with
// index and data on a write there while the DSP address is below 0x80.
module audio_cpu_io_timers #(
  parameter int TIMER_COUNT   = 3,
  parameter int SLOW_PRESCALE = 128,
  parameter int FAST_PRESCALE = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  acit_pkg::in_item_t  item_i,
  output logic                busy,
  output logic                done_o,
  output acit_pkg::out_item_t result_o
);

  import acit_pkg::*;

  // RAM clearing pass after reset
  logic              clearing_q;
  logic [RAM_AW-1:0] clr_addr_q;

  // Decode stage
  logic      accept;
  logic      valid_q;
  in_item_t  item_q;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  // Architectural registers
  logic [7:0] dsp_addr_q;
  logic [7:0] in_ports_q  [IN_PORTS];
  logic [7:0] out_ports_q [OUT_PORTS];
  logic       rom_vis_q;

  logic [CNT_W-1:0] tmr_cnt [MAX_TIMERS];

  logic       cpu_rd;
  logic       cpu_wr;
  logic       host_wr;
  logic [2:0] in_idx;
  logic [1:0] cnt_idx;

  out_item_t result_d;
  out_item_t result_q;
  logic      done_q;

  assign busy   = clearing_q;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      // Advance through every byte; drop out of the pass after the last one.
      clr_addr_q <= clr_addr_q + RAM_AW'(1);
      if (clr_addr_q == {RAM_AW{1'b1}}) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Every CPU write lands in RAM, I/O addresses included.
  assign ram_we    = clearing_q || (accept && kind_e'(item_i.kind) == KIND_CPU_WR);
  assign ram_waddr = clearing_q ? clr_addr_q : item_i.address;
  assign ram_wdata = clearing_q ? 8'h00 : item_i.write_data;

  acit_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (item_i.address),
    .rdata_o (ram_rdata)
  );

  // Hold the taken beat for the decode cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign cpu_rd  = valid_q && kind_e'(item_q.kind) == KIND_CPU_RD;
  assign cpu_wr  = valid_q && kind_e'(item_q.kind) == KIND_CPU_WR;
  assign host_wr = valid_q && kind_e'(item_q.kind) == KIND_HOST_WR;

  // Ports 0xF4..0xF9 map to in_ports 0..5; counters 0xFD..0xFF to timers 0..2.
  assign in_idx  = 3'(item_q.address[3:0] - 4'h4);
  assign cnt_idx = item_q.address[1:0] - 2'd1;

  // Timers: missing ones read as zero and ignore their enable bits.
  for (genvar t = 0; t < MAX_TIMERS; t++) begin : g_tmr
    if (t < TIMER_COUNT) begin : g_on
      tmr_ctl_t ctl;
      assign ctl.tick    = valid_q && kind_e'(item_q.kind) == KIND_TICK;
      assign ctl.ctl_wr  = cpu_wr && item_q.address == ADDR_CONTROL;
      assign ctl.en      = item_q.write_data[t];
      assign ctl.tgt_wr  = cpu_wr && item_q.address == ADDR_T0_TGT + 16'(t);
      assign ctl.tgt     = item_q.write_data;
      assign ctl.cnt_clr = cpu_rd && item_q.address == ADDR_T0_CNT + 16'(t);

      acit_timer #(
        .PRESCALE ((t == 2) ? FAST_PRESCALE : SLOW_PRESCALE)
      ) u_timer (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl),
        .cnt_o  (tmr_cnt[t])
      );
    end else begin : g_off
      assign tmr_cnt[t] = '0;
    end
  end

  // Port, DSP address and overlay registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dsp_addr_q <= '0;
      rom_vis_q  <= 1'b1;
      for (int i = 0; i < IN_PORTS; i++) begin
        in_ports_q[i] <= '0;
      end
      for (int i = 0; i < OUT_PORTS; i++) begin
        out_ports_q[i] <= '0;
      end
    end else begin
      if (cpu_wr) begin
        case (item_q.address)
          ADDR_CONTROL: begin
            if (item_q.write_data[CTL_CLR_P01]) begin
              in_ports_q[0] <= '0;
              in_ports_q[1] <= '0;
            end
            if (item_q.write_data[CTL_CLR_P23]) begin
              in_ports_q[2] <= '0;
              in_ports_q[3] <= '0;
            end
            rom_vis_q <= item_q.write_data[CTL_ROM_EN];
          end
          ADDR_DSP_ADDR: dsp_addr_q <= item_q.write_data;
          ADDR_PORT0, ADDR_PORT1, ADDR_PORT2, ADDR_PORT3: begin
            out_ports_q[item_q.address[1:0]] <= item_q.write_data;
          end
          ADDR_PORT4, ADDR_PORT5: in_ports_q[in_idx] <= item_q.write_data;
          default: ;
        endcase
      end
      if (host_wr) begin
        in_ports_q[3'(item_q.port)] <= item_q.write_data;
      end
    end
  end

  // Build the result beat.
  always_comb begin
    result_d = '0;
    if (valid_q) begin
      case (kind_e'(item_q.kind))
        KIND_CPU_RD: begin
          case (item_q.address)
            ADDR_TEST, ADDR_CONTROL, ADDR_T0_TGT, ADDR_T1_TGT, ADDR_T2_TGT: begin
              result_d.read_data = '0;
            end
            ADDR_DSP_ADDR: result_d.read_data = dsp_addr_q;
            ADDR_DSP_DATA: begin
              result_d.read_data       = item_q.dsp_read_data;
              result_d.dsp_read_strobe = 1'b1;
              result_d.dsp_register    = dsp_addr_q[6:0];
            end
            ADDR_PORT0, ADDR_PORT1, ADDR_PORT2, ADDR_PORT3, ADDR_PORT4, ADDR_PORT5: begin
              result_d.read_data = in_ports_q[in_idx];
            end
            ADDR_T0_CNT, ADDR_T1_CNT, ADDR_T2_CNT: begin
              result_d.read_data = 8'(tmr_cnt[cnt_idx]);
            end
            default: begin
              if (rom_vis_q && item_q.address >= ROM_BASE) begin
                result_d.read_data = BOOT_ROM[item_q.address[ROM_AW-1:0]];
              end else begin
                result_d.read_data = ram_rdata;
              end
            end
          endcase
        end
        KIND_CPU_WR: begin
          // DSP registers at 0x80 and above are read-only mirrors: no strobe.
          if (item_q.address == ADDR_DSP_DATA && !dsp_addr_q[7]) begin
            result_d.dsp_write_strobe = 1'b1;
            result_d.dsp_register     = dsp_addr_q[6:0];
            result_d.dsp_write_data   = item_q.write_data;
          end
        end
        KIND_HOST_RD: result_d.read_data = out_ports_q[item_q.port];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

FILE: rtl/acit_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/acit_timer.sv
// One interval timer: prescaler, 8-bit divider against a target, 4-bit tick counter.
module acit_timer #(
  parameter int PRESCALE = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  acit_pkg::tmr_ctl_t       ctl_i,
  output logic [acit_pkg::CNT_W-1:0] cnt_o
);

  import acit_pkg::*;

  localparam logic [PRE_W-1:0] RELOAD = PRE_W'((PRESCALE - 1) % 128);

  logic [PRE_W-1:0] pre_q;
  logic [7:0]       div_q;
  logic [7:0]       div_inc;
  logic [7:0]       tgt_q;
  logic [CNT_W-1:0] cnt_q;
  logic             en_q;

  assign div_inc = div_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= '0;
      div_q <= '0;
      tgt_q <= '0;
      cnt_q <= '0;
      en_q  <= 1'b0;
    end else begin
      if (ctl_i.tick) begin
        if (pre_q == '0) begin
          pre_q <= RELOAD;
          if (en_q) begin
            // A target of zero wraps the divider through 256 steps.
            if (div_inc == tgt_q) begin
              div_q <= '0;
              cnt_q <= cnt_q + CNT_W'(1);
            end else begin
              div_q <= div_inc;
            end
          end
        end else begin
          pre_q <= pre_q - PRE_W'(1);
        end
      end
      if (ctl_i.ctl_wr) begin
        if (!en_q && ctl_i.en) begin
          div_q <= '0;
          cnt_q <= '0;
        end
        en_q <= ctl_i.en;
      end
      if (ctl_i.tgt_wr) begin
        tgt_q <= ctl_i.tgt;
      end
      if (ctl_i.cnt_clr) begin
        cnt_q <= '0;
      end
    end
  end

  assign cnt_o = cnt_q;

endmodule
